// File: sv/bounded_sorted_priority_list_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef BOUNDED_SORTED_PRIORITY_LIST_MACROS_SVH
`define BOUNDED_SORTED_PRIORITY_LIST_MACROS_SVH

// property checked on every clock edge outside reset
`define BSPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BSPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bspl_pkg.sv
`timescale 1ns / 1ps

package bspl_pkg;

  // default sizing
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_BITS_DEF  = 16;

  // result field widths and layout
  localparam int HEAD_ID_BITS  = 16;
  localparam int COUNT_BITS    = 7;
  localparam int STATUS_BITS   = 2;
  localparam int OUT_USED_BITS = HEAD_ID_BITS + 1 + COUNT_BITS + STATUS_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY_REMOVE = 2'd1,
    ST_DROPPED      = 2'd2,
    ST_EVICTED      = 2'd3
  } status_t;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic do_ins;
    logic do_rem;
  } cell_ctl_t;

endpackage

// File: sv/bspl_cell.sv
`timescale 1ns / 1ps

module bspl_cell #(
  parameter int KEY_BITS = bspl_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = bspl_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  bspl_pkg::cell_ctl_t        ctl,
  input  logic                       occupied,
  input  logic                       left_ge,
  input  logic signed [KEY_BITS-1:0] new_key,
  input  logic        [ID_BITS-1:0]  new_id,
  input  logic signed [KEY_BITS-1:0] left_key,
  input  logic        [ID_BITS-1:0]  left_id,
  input  logic signed [KEY_BITS-1:0] right_key,
  input  logic        [ID_BITS-1:0]  right_id,
  output logic signed [KEY_BITS-1:0] key_r,
  output logic        [ID_BITS-1:0]  id_r,
  output logic        [ID_BITS-1:0]  id_nxt,
  output logic                       ge
);

  logic signed [KEY_BITS-1:0] key_nxt;

  // held entry stays ahead of the new one: equal keys keep arrival order
  assign ge = occupied && (key_r >= new_key);

  // keep, take the new entry, shift from the left on insert, from the right on remove
  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    if (ctl.do_ins && !ge) begin
      if (left_ge) begin
        key_nxt = new_key;
        id_nxt  = new_id;
      end else begin
        key_nxt = left_key;
        id_nxt  = left_id;
      end
    end else if (ctl.do_rem) begin
      key_nxt = right_key;
      id_nxt  = right_id;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

endmodule

// File: sv/bounded_sorted_priority_list.sv
`timescale 1ns / 1ps
// channel | direction | tdata (lowest bit up)                         | tuser
// in_     | slave     | key, item_id, zero fill                       | command
// out_    | master    | head_id, head_valid, entry_count, status, fill | -
//
// one transaction per cycle while out_tready is high; the result sits in the
// output register in the cycle after acceptance
// every cell compares its key with the new key in the same cycle and shifts
// one place on an insert or remove; a clear only resets the entry count
// reset clears the entry count and the output valid; cell contents stay
// undefined until written and are never read outside the entry count
// in_tready is low only while a result is held and out_tready is low

`include "bounded_sorted_priority_list_macros.svh"

module bounded_sorted_priority_list #(
  parameter int CAPACITY = bspl_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = bspl_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = bspl_pkg::ID_BITS_DEF,
  localparam int IN_DATA_BITS = ((KEY_BITS + ID_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_DATA_BITS-1:0]            in_tdata,  // key, item_id, zero fill
  input  logic [1:0]                         in_tuser,  // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bspl_pkg::OUT_DATA_BITS-1:0] out_tdata  // head_id, head_valid,
                                                        // entry_count, status, fill
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                       in_acc;
  bspl_pkg::cmd_t             cmd;
  bspl_pkg::cell_ctl_t        ctl;
  logic signed [KEY_BITS-1:0] new_key;
  logic        [ID_BITS-1:0]  new_id;

  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       full, drop;
  bspl_pkg::status_t          status;

  logic signed [KEY_BITS-1:0] key_q  [CAPACITY];
  logic        [ID_BITS-1:0]  id_q   [CAPACITY];
  logic        [ID_BITS-1:0]  id_nx  [CAPACITY];
  logic                       ge     [CAPACITY];

  logic                               out_valid_r;
  logic [bspl_pkg::OUT_DATA_BITS-1:0] out_data_r;
  logic                               head_valid_nxt;
  logic [bspl_pkg::HEAD_ID_BITS-1:0]  head_id_nxt;
  logic                               out_flag_ok;

  // input handshake and field unpacking
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = bspl_pkg::cmd_t'(in_tuser);
  assign new_key   = in_tdata[KEY_BITS-1:0];
  assign new_id    = in_tdata[KEY_BITS +: ID_BITS];

  assign ctl.do_ins = in_acc && (cmd == bspl_pkg::CMD_INSERT);
  assign ctl.do_rem = in_acc && (cmd == bspl_pkg::CMD_REMOVE);

  // row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       occ;
    logic                       lge;
    logic signed [KEY_BITS-1:0] lkey, rkey;
    logic        [ID_BITS-1:0]  lid, rid;

    assign occ = count_r > CNT_W'(i);

    if (i == 0) begin : g_head
      assign lge  = 1'b1;
      assign lkey = new_key;
      assign lid  = new_id;
    end else begin : g_mid
      assign lge  = ge[i-1];
      assign lkey = key_q[i-1];
      assign lid  = id_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rkey = key_q[i];
      assign rid  = id_q[i];
    end else begin : g_body
      assign rkey = key_q[i+1];
      assign rid  = id_q[i+1];
    end

    bspl_cell #(
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ),
      .left_ge   (lge),
      .new_key   (new_key),
      .new_id    (new_id),
      .left_key  (lkey),
      .left_id   (lid),
      .right_key (rkey),
      .right_id  (rid),
      .key_r     (key_q[i]),
      .id_r      (id_q[i]),
      .id_nxt    (id_nx[i]),
      .ge        (ge[i])
    );
  end

  // a full row whose last entry is not below the new key drops the insert
  assign full = count_r == CNT_W'(CAPACITY);
  assign drop = full && ge[CAPACITY-1];

  // count and status decode
  always_comb begin
    count_nxt = count_r;
    status    = bspl_pkg::ST_OK;
    unique case (cmd)
      bspl_pkg::CMD_INSERT: begin
        if (drop) begin
          status = bspl_pkg::ST_DROPPED;
        end else if (full) begin
          status = bspl_pkg::ST_EVICTED;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bspl_pkg::CMD_REMOVE: begin
        if (count_r == '0) begin
          status = bspl_pkg::ST_EMPTY_REMOVE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bspl_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // head after the operation
  assign head_valid_nxt = count_nxt != '0;
  assign head_id_nxt    = head_valid_nxt ? bspl_pkg::HEAD_ID_BITS'(id_nx[0]) : '0;

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {{bspl_pkg::OUT_PAD_BITS{1'b0}}, status,
                     bspl_pkg::COUNT_BITS'(count_nxt), head_valid_nxt, head_id_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // head flag of the held result agrees with its count
  assign out_flag_ok = out_data_r[bspl_pkg::HEAD_ID_BITS] ==
                       (out_data_r[bspl_pkg::HEAD_ID_BITS+1 +: bspl_pkg::COUNT_BITS] != '0);

  // checks
  `BSPL_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `BSPL_ASSERT(a_head_order, (count_r >= CNT_W'(2)) |-> (key_q[0] >= key_q[1]), "head order")
  `BSPL_ASSERT(a_drop_keeps, (ctl.do_ins && drop) |=> $stable(count_r), "drop moved count")
  `BSPL_ASSERT(a_result_follows, in_acc |=> out_valid_r, "accepted item gave no result")
  `BSPL_ASSERT(a_valid_matches, out_valid_r |-> out_flag_ok, "head flag disagrees with count")

endmodule
